/* src/key_swing_capture_macros.svh */
// Assertion macros shared by the key swing capture RTL.
`ifndef KEY_SWING_CAPTURE_MACROS_SVH
`define KEY_SWING_CAPTURE_MACROS_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define KSC_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define KSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define KSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define KSC_ASSERT_HOLD(lbl, cond, msg)
`define KSC_ASSERT_IMP(lbl, ante, cons, msg)
`define KSC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* src/ksc_pkg.sv */
// Types, codes and constants of the key swing capture block.
package ksc_pkg;

    localparam int KSC_NUM_KEYS      = 16;
    localparam int KSC_PREROLL_DEPTH = 16;
    localparam int KSC_CAPTURE_DEPTH = 512;

    localparam int          REST_SHIFT     = 10;
    localparam logic [16:0] QUIET_MAX      = 17'h1FFFF;
    localparam logic [16:0] QUIET_DEFAULT  = 17'd36;
    localparam logic [16:0] QUIET_FLOOR    = 17'd4;
    localparam logic [31:0] PERIOD_LIMIT   = 32'd100000;
    localparam logic [31:0] DROP_TIME_US   = 32'd1000000;
    localparam logic [15:0] AMP_MAX        = 16'hFFFF;
    localparam logic [15:0] DIV5_RECIP     = 16'd52429;
    localparam int          DIV5_SHIFT     = 18;
    localparam logic [19:0] MS_TO_US       = 20'd1000;
    localparam int          DIV_WIDTH      = 20;
    localparam int          PERIOD_WIDTH   = 17;

    localparam logic [15:0] THR_RESET      = 16'd256;
    localparam logic [15:0] MIN_AMP_RESET  = 16'd1024;
    localparam logic [9:0]  END_MS_RESET   = 10'd60;

    typedef enum logic [1:0] {
        OP_SWEEP   = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_READ    = 2'd2,
        OP_RELEASE = 2'd3
    } ksc_op_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_IGNORED = 3'd1,
        EV_STARTED = 3'd2,
        EV_DONE    = 3'd3,
        EV_DROPPED = 3'd4,
        EV_MISSED  = 3'd5
    } ksc_event_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_DONE   = 2'd2
    } ksc_mode_t;

    typedef enum logic [2:0] {
        CFG_START_THR = 3'd0,
        CFG_MIN_AMP   = 3'd1,
        CFG_END_MS    = 3'd2,
        CFG_DISABLED  = 3'd3,
        CFG_INVERTED  = 3'd4
    } ksc_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_PRESS,
        ST_ACT_STORE,
        ST_NEAR,
        ST_ACT_JUDGE,
        ST_REST_JUDGE,
        ST_COPY,
        ST_MISS_JUDGE,
        ST_FILTER,
        ST_READ,
        ST_WRITEBACK,
        ST_FINISH
    } ksc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ksc_div_status_t;

endpackage

/* src/ksc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module ksc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* src/ksc_divider.sv */
// Restoring divider, one quotient bit per cycle, for the quiet sample count.
module ksc_divider (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [ksc_pkg::DIV_WIDTH-1:0]         dividend,
    input  logic [ksc_pkg::PERIOD_WIDTH-1:0]      divisor,
    output logic [ksc_pkg::DIV_WIDTH-1:0]         quotient,
    output ksc_pkg::ksc_div_status_t              status
);
    import ksc_pkg::*;

    localparam int CW = $clog2(DIV_WIDTH);

    logic                    run_reg;
    logic                    done_reg;
    logic [CW-1:0]           cnt_reg;
    logic [PERIOD_WIDTH:0]   rem_reg;
    logic [DIV_WIDTH-1:0]    quo_reg;
    logic [PERIOD_WIDTH-1:0] dsr_reg;
    logic [PERIOD_WIDTH:0]   rem_shift;
    logic [PERIOD_WIDTH:0]   rem_next;
    logic                    bit_next;

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        rem_shift = {rem_reg[PERIOD_WIDTH-1:0], quo_reg[DIV_WIDTH-1]};
        bit_next  = rem_shift >= {1'b0, dsr_reg};
        rem_next  = bit_next ? rem_shift - {1'b0, dsr_reg} : rem_shift;
    end

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_WIDTH - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_WIDTH-2:0], bit_next};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = run_reg;
    assign status.done = done_reg;

endmodule

/* src/key_swing_capture.sv */
// Top level of the key swing capture block: sequencer, key state and stores.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  request  | req_valid / req_ready | opcode key_index reading time_us enable
//           |                       | read_index
//  response | rsp_valid / rsp_ready | event_res key_mode amplitude capture_length
//           |                       | preroll_length truncated read_sample ...
//  config   | cfg_valid / cfg_ready | cfg_index cfg_data
//
// A sample that starts a swing also copies its pre-roll words through the ring
// RAM read port, and a sweep beat that recomputes the quiet count while capture
// stays enabled waits for the one-bit-per-cycle divider.
// Reset clears control and per-key state, but not the swing start and end times;
// the RAMs need no clearing.
// A response beat waits in its register while the next request is taken;
// the sequencer stalls in its last step only while both are still pending.
module key_swing_capture #(
    parameter int NUM_KEYS      = ksc_pkg::KSC_NUM_KEYS,
    parameter int PREROLL_DEPTH = ksc_pkg::KSC_PREROLL_DEPTH,
    parameter int CAPTURE_DEPTH = ksc_pkg::KSC_CAPTURE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  opcode,
    input  logic [3:0]  key_index,
    input  logic [15:0] reading,
    input  logic [31:0] time_us,
    input  logic        enable,
    input  logic [8:0]  read_index,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  event_res,
    output logic [1:0]  key_mode,
    output logic [15:0] amplitude,
    output logic [9:0]  capture_length,
    output logic [4:0]  preroll_length,
    output logic        truncated,
    output logic [15:0] read_sample,
    output logic [15:0] swing_count,
    output logic [15:0] missed_count,
    output logic [31:0] start_time_us,
    output logic [31:0] end_time_us,
    output logic [15:0] rest_level,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ksc_pkg::*;

    localparam int KW   = NUM_KEYS > 1 ? $clog2(NUM_KEYS) : 1;
    localparam int PW   = PREROLL_DEPTH > 1 ? $clog2(PREROLL_DEPTH) : 1;
    localparam int FW   = $clog2(PREROLL_DEPTH + 1);
    localparam int CLW  = $clog2(CAPTURE_DEPTH + 1);
    localparam int CIW  = $clog2(CAPTURE_DEPTH);
    localparam int RD   = NUM_KEYS * PREROLL_DEPTH;
    localparam int RAW  = RD > 1 ? $clog2(RD) : 1;
    localparam int SD   = NUM_KEYS * CAPTURE_DEPTH;
    localparam int SAW  = $clog2(SD);

    // Configuration
    logic [15:0] thr_reg, min_amp_reg, dis_reg, inv_reg;
    logic [9:0]  end_ms_reg;

    // Global sweep state
    ksc_state_t        state_reg, state_next;
    logic              cap_on_reg;
    logic [16:0]       period_reg;
    logic [31:0]       last_reg;
    logic [16:0]       qneed_reg;

    // Latched request
    logic [1:0]  op_reg;
    logic [3:0]  key_reg;
    logic [15:0] v_reg;
    logic [31:0] now_reg;
    logic        en_reg;
    logic [8:0]  ridx_reg;

    // Per-key state
    ksc_mode_t        mode_reg   [NUM_KEYS];
    logic [25:0]      rfix_reg   [NUM_KEYS];
    logic [15:0]      rest_reg   [NUM_KEYS];
    logic [15:0]      peak_reg   [NUM_KEYS];
    logic [15:0]      mpeak_reg  [NUM_KEYS];
    logic             trunc_reg  [NUM_KEYS];
    logic             uncap_reg  [NUM_KEYS];
    logic [16:0]      quiet_reg  [NUM_KEYS];
    logic [PW-1:0]    head_reg   [NUM_KEYS];
    logic [FW-1:0]    fill_reg   [NUM_KEYS];
    logic [CLW-1:0]   caplen_reg [NUM_KEYS];
    logic [FW-1:0]    prelen_reg [NUM_KEYS];
    logic [15:0]      swings_reg [NUM_KEYS];
    logic [15:0]      missed_reg [NUM_KEYS];
    logic [31:0]      tstart_reg [NUM_KEYS];
    logic [31:0]      tend_reg   [NUM_KEYS];

    // Working copy of the selected key
    ksc_mode_t      wk_mode_reg;
    logic [25:0]    wk_rfix_reg;
    logic [15:0]    wk_rest_reg, wk_peak_reg, wk_mpeak_reg;
    logic           wk_trunc_reg, wk_uncap_reg;
    logic [16:0]    wk_quiet_reg;
    logic [PW-1:0]  wk_head_reg;
    logic [FW-1:0]  wk_fill_reg, wk_prelen_reg;
    logic [CLW-1:0] wk_caplen_reg;
    logic [15:0]    wk_swings_reg, wk_missed_reg;
    logic [31:0]    wk_tstart_reg, wk_tend_reg;

    // Step scratch
    logic signed [17:0] press_reg, nb_reg;
    ksc_event_t         ev_reg;
    logic [15:0]        rd_reg;
    logic [FW-1:0]      copy_cnt_reg, copy_wr_reg;
    logic [PW-1:0]      copy_pos_reg;
    logic               copy_pend_reg;

    // Response register
    logic        rsp_valid_reg;
    ksc_event_t  o_ev_reg;
    ksc_mode_t   o_mode_reg;
    logic [15:0] o_amp_reg, o_rd_reg, o_swings_reg, o_missed_reg, o_rest_reg;
    logic [9:0]  o_caplen_reg;
    logic [4:0]  o_prelen_reg;
    logic        o_trunc_reg;
    logic [31:0] o_tstart_reg, o_tend_reg;

    // Shared units and memories
    logic [DIV_WIDTH-1:0] div_quo;
    ksc_div_status_t      div_st;
    logic                 div_start;
    logic                 ring_we, ring_re, store_we, store_re;
    logic [RAW-1:0]       ring_waddr, ring_raddr;
    logic [SAW-1:0]       store_waddr, store_raddr;
    logic [15:0]          ring_rdata, store_rdata, store_wdata;
    logic [CIW-1:0]       store_woff;

    // Decode helpers
    logic [KW-1:0]      key_sel;
    logic               key_ok;
    logic               ignore_sample;
    logic               sweep_toggle;
    logic [31:0]        period_raw;
    logic [16:0]        period_new;
    logic [DIV_WIDTH-1:0] q_clamp;
    logic signed [17:0] thr_s, thr_neg, thr_half;
    logic signed [17:0] p_adj;
    logic               low_reset, start_go, miss_new, uncap_after;
    logic [FW-1:0]      pre_n;
    logic [PW:0]        base_sum;
    logic [PW-1:0]      copy_base;
    logic [15:0]        mpeak_base, mpeak_new, peak_new, near_amp;
    logic [31:0]        near_prod;
    logic [15:0]        near_div5;
    logic signed [17:0] near_bound;
    logic [16:0]        quiet_inc;
    logic               is_quiet, end_now, drop_now;
    logic [31:0]        dt;
    logic signed [26:0] rest_diff, rest_step, rest_sum;
    logic               filter_on;
    logic               rsp_load;
    logic               act_store_ok;

    assign key_sel = KW'(key_reg);
    assign key_ok  = 32'(key_reg) < NUM_KEYS;

    // Work out decode conditions
    always_comb
    begin
        ignore_sample = !cap_on_reg || !key_ok || dis_reg[key_reg] || (v_reg == 16'd0);
        sweep_toggle  = en_reg != cap_on_reg;
        period_raw    = now_reg - last_reg;
        period_new    = ((period_raw != 32'd0) && (period_raw < PERIOD_LIMIT))
                      ? period_raw[16:0] : period_reg;
        if (div_quo < DIV_WIDTH'(QUIET_FLOOR))
        begin
            q_clamp = DIV_WIDTH'(QUIET_FLOOR);
        end
        else if (div_quo > DIV_WIDTH'(QUIET_MAX))
        begin
            q_clamp = DIV_WIDTH'(QUIET_MAX);
        end
        else
        begin
            q_clamp = div_quo;
        end
    end

    // Judge a press while the key rests
    always_comb
    begin
        thr_s       = $signed({2'b00, thr_reg});
        thr_neg     = -thr_s;
        thr_half    = $signed({3'b000, thr_reg[15:1]});
        low_reset   = press_reg < thr_neg;
        p_adj       = low_reset ? 18'sd0 : press_reg;
        start_go    = (p_adj > thr_s) && (wk_mode_reg == MODE_IDLE) && !wk_uncap_reg;
        miss_new    = (p_adj > thr_s) && !wk_uncap_reg && !start_go;
        uncap_after = wk_uncap_reg || miss_new;
        mpeak_base  = miss_new ? 16'd0 : wk_mpeak_reg;
        mpeak_new   = (p_adj > $signed({2'b00, mpeak_base})) ? p_adj[15:0] : mpeak_base;
        pre_n       = (CLW'(wk_fill_reg) > CLW'(CAPTURE_DEPTH - 1))
                    ? FW'(CAPTURE_DEPTH - 1) : wk_fill_reg;
        base_sum    = (PW + 1)'(wk_head_reg) + (PW + 1)'(PREROLL_DEPTH) - (PW + 1)'(pre_n);
        copy_base   = (base_sum >= (PW + 1)'(PREROLL_DEPTH))
                    ? PW'(base_sum - (PW + 1)'(PREROLL_DEPTH)) : PW'(base_sum);
    end

    // Form the near-rest bound from the peak
    always_comb
    begin
        near_amp   = (wk_mode_reg == MODE_ACTIVE) ? wk_peak_reg : wk_mpeak_reg;
        near_prod  = near_amp * DIV5_RECIP;
        near_div5  = 16'(near_prod >> DIV5_SHIFT);
        near_bound = ($signed({2'b00, near_div5}) > thr_half)
                   ? $signed({2'b00, near_div5}) : thr_half;
    end

    // Track the active swing
    always_comb
    begin
        act_store_ok = wk_caplen_reg < CLW'(CAPTURE_DEPTH);
        peak_new   = (press_reg > $signed({2'b00, wk_peak_reg}))
                   ? ((press_reg > $signed({2'b00, AMP_MAX})) ? AMP_MAX : press_reg[15:0])
                   : wk_peak_reg;
        is_quiet   = press_reg < nb_reg;
        quiet_inc  = (wk_quiet_reg < QUIET_MAX) ? wk_quiet_reg + 17'd1 : wk_quiet_reg;
        end_now    = is_quiet && (quiet_inc >= qneed_reg);
        dt         = now_reg - wk_tstart_reg;
        drop_now   = !end_now && (wk_peak_reg < min_amp_reg) && (dt > DROP_TIME_US) && !dt[31];
    end

    // Drift the rest baseline, truncating the step toward zero
    always_comb
    begin
        rest_diff = $signed({1'b0, v_reg, 10'd0}) - $signed({1'b0, wk_rfix_reg});
        rest_step = rest_diff[26] ? ((rest_diff + 27'sd1023) >>> REST_SHIFT)
                                  : (rest_diff >>> REST_SHIFT);
        rest_sum  = $signed({1'b0, wk_rfix_reg}) + rest_step;
        filter_on = (press_reg < thr_half) && (press_reg > thr_neg);
    end

    assign rsp_load = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready);

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority case (op_reg)
                    OP_SWEEP:
                    begin
                        if (!sweep_toggle && en_reg && (period_new != 17'd0))
                        begin
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    OP_SAMPLE:  state_next = ignore_sample ? ST_FINISH : ST_PRESS;
                    OP_READ:    state_next = store_re ? ST_READ : ST_FINISH;
                    default:    state_next = ST_FINISH;
                endcase
            end
            ST_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PRESS:
            begin
                state_next = (wk_mode_reg == MODE_ACTIVE) ? ST_ACT_STORE : ST_REST_JUDGE;
            end
            ST_ACT_STORE:  state_next = ST_NEAR;
            ST_NEAR:
            begin
                state_next = (wk_mode_reg == MODE_ACTIVE) ? ST_ACT_JUDGE : ST_MISS_JUDGE;
            end
            ST_ACT_JUDGE:  state_next = ST_WRITEBACK;
            ST_REST_JUDGE:
            begin
                if (start_go)
                begin
                    state_next = ST_COPY;
                end
                else if (uncap_after)
                begin
                    state_next = ST_NEAR;
                end
                else
                begin
                    state_next = ST_FILTER;
                end
            end
            ST_COPY:
            begin
                if ((copy_cnt_reg == wk_prelen_reg) && !copy_pend_reg)
                begin
                    state_next = ST_WRITEBACK;
                end
            end
            ST_MISS_JUDGE:
            begin
                state_next = (press_reg >= nb_reg) ? ST_WRITEBACK : ST_FILTER;
            end
            ST_FILTER:     state_next = ST_WRITEBACK;
            ST_READ:       state_next = ST_FINISH;
            ST_WRITEBACK:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Drive handshakes, divider start and memory ports
    always_comb
    begin
        req_ready  = state_reg == ST_IDLE;
        div_start  = (state_reg == ST_DECODE) && (op_reg == OP_SWEEP) && !sweep_toggle
                   && en_reg && (period_new != 17'd0);
        store_re   = (state_reg == ST_DECODE) && (op_reg == OP_READ) && key_ok
                   && (32'(ridx_reg) < 32'(caplen_reg[key_sel]))
                   && (32'(ridx_reg) < CAPTURE_DEPTH);
        store_we   = 1'b0;
        store_woff = CIW'(wk_caplen_reg);
        store_wdata = v_reg;
        ring_re    = (state_reg == ST_COPY) && (copy_cnt_reg < wk_prelen_reg);
        ring_we    = state_reg == ST_FILTER;
        unique case (state_reg)
            ST_ACT_STORE:
            begin
                store_we = act_store_ok;
            end
            ST_REST_JUDGE:
            begin
                store_we   = start_go;
                store_woff = CIW'(pre_n);
            end
            ST_COPY:
            begin
                store_we    = copy_pend_reg;
                store_woff  = CIW'(copy_wr_reg);
                store_wdata = ring_rdata;
            end
            default:
            begin
                store_we = 1'b0;
            end
        endcase
        store_waddr = SAW'(key_sel) * SAW'(CAPTURE_DEPTH) + SAW'(store_woff);
        store_raddr = SAW'(key_sel) * SAW'(CAPTURE_DEPTH) + SAW'(CIW'(ridx_reg));
        ring_waddr  = RAW'(key_sel) * RAW'(PREROLL_DEPTH) + RAW'(wk_head_reg);
        ring_raddr  = RAW'(key_sel) * RAW'(PREROLL_DEPTH) + RAW'(copy_pos_reg);
    end

    // Hold the sequencer state and global sweep state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_on_reg    <= 1'b0;
            period_reg    <= '0;
            last_reg      <= '0;
            qneed_reg     <= QUIET_DEFAULT;
            copy_pend_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DECODE) && (op_reg == OP_SWEEP))
            begin
                if (sweep_toggle)
                begin
                    cap_on_reg <= en_reg;
                    if (en_reg)
                    begin
                        period_reg <= '0;
                        last_reg   <= now_reg;
                        qneed_reg  <= QUIET_DEFAULT;
                    end
                end
                else if (en_reg)
                begin
                    last_reg   <= now_reg;
                    period_reg <= period_new;
                    if (period_new == 17'd0)
                    begin
                        qneed_reg <= QUIET_DEFAULT;
                    end
                end
            end
            if ((state_reg == ST_DIV) && div_st.done)
            begin
                qneed_reg <= 17'(q_clamp);
            end
            if (state_reg == ST_COPY)
            begin
                copy_pend_reg <= ring_re;
            end
            else
            begin
                copy_pend_reg <= 1'b0;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THR_RESET;
            min_amp_reg <= MIN_AMP_RESET;
            end_ms_reg  <= END_MS_RESET;
            dis_reg     <= '0;
            inv_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_THR: thr_reg     <= cfg_data;
                CFG_MIN_AMP:   min_amp_reg <= cfg_data;
                CFG_END_MS:    end_ms_reg  <= cfg_data[9:0];
                CFG_DISABLED:  dis_reg     <= cfg_data;
                CFG_INVERTED:  inv_reg     <= cfg_data;
                default:       thr_reg     <= thr_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Step the working copy and scratch through the sequence
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                op_reg   <= opcode;
                key_reg  <= key_index;
                v_reg    <= reading;
                now_reg  <= time_us;
                en_reg   <= enable;
                ridx_reg <= read_index;
            end
            ST_DECODE:
            begin
                ev_reg <= ((op_reg == OP_SAMPLE) && ignore_sample) ? EV_IGNORED : EV_NONE;
                rd_reg <= '0;
                wk_mode_reg   <= mode_reg[key_sel];
                wk_peak_reg   <= peak_reg[key_sel];
                wk_mpeak_reg  <= mpeak_reg[key_sel];
                wk_trunc_reg  <= trunc_reg[key_sel];
                wk_uncap_reg  <= uncap_reg[key_sel];
                wk_quiet_reg  <= quiet_reg[key_sel];
                wk_head_reg   <= head_reg[key_sel];
                wk_fill_reg   <= fill_reg[key_sel];
                wk_caplen_reg <= caplen_reg[key_sel];
                wk_prelen_reg <= prelen_reg[key_sel];
                wk_swings_reg <= swings_reg[key_sel];
                wk_missed_reg <= missed_reg[key_sel];
                wk_tstart_reg <= tstart_reg[key_sel];
                wk_tend_reg   <= tend_reg[key_sel];
                if (rest_reg[key_sel] == 16'd0)
                begin
                    wk_rest_reg <= v_reg;
                    wk_rfix_reg <= {v_reg, 10'd0};
                end
                else
                begin
                    wk_rest_reg <= rest_reg[key_sel];
                    wk_rfix_reg <= rfix_reg[key_sel];
                end
            end
            ST_PRESS:
            begin
                press_reg <= inv_reg[key_reg]
                           ? $signed({2'b00, wk_rest_reg}) - $signed({2'b00, v_reg})
                           : $signed({2'b00, v_reg}) - $signed({2'b00, wk_rest_reg});
            end
            ST_ACT_STORE:
            begin
                if (act_store_ok)
                begin
                    wk_caplen_reg <= wk_caplen_reg + 1'b1;
                end
                else
                begin
                    wk_trunc_reg <= 1'b1;
                end
                wk_peak_reg <= peak_new;
            end
            ST_NEAR:
            begin
                nb_reg <= near_bound;
            end
            ST_ACT_JUDGE:
            begin
                wk_quiet_reg <= is_quiet ? quiet_inc : 17'd0;
                if (end_now)
                begin
                    wk_tend_reg   <= now_reg;
                    wk_swings_reg <= wk_swings_reg + 16'd1;
                    wk_rest_reg   <= v_reg;
                    wk_rfix_reg   <= {v_reg, 10'd0};
                    wk_mode_reg   <= MODE_DONE;
                    ev_reg        <= EV_DONE;
                end
                else if (drop_now)
                begin
                    wk_rest_reg <= v_reg;
                    wk_rfix_reg <= {v_reg, 10'd0};
                    wk_mode_reg <= MODE_IDLE;
                    ev_reg      <= EV_DROPPED;
                end
            end
            ST_REST_JUDGE:
            begin
                press_reg <= p_adj;
                if (low_reset)
                begin
                    wk_rest_reg <= v_reg;
                    wk_rfix_reg <= {v_reg, 10'd0};
                end
                if (start_go)
                begin
                    wk_prelen_reg <= pre_n;
                    wk_caplen_reg <= CLW'(pre_n) + 1'b1;
                    wk_fill_reg   <= '0;
                    wk_head_reg   <= '0;
                    wk_trunc_reg  <= 1'b0;
                    wk_quiet_reg  <= '0;
                    wk_peak_reg   <= p_adj[15:0];
                    wk_tstart_reg <= now_reg;
                    wk_mode_reg   <= MODE_ACTIVE;
                    ev_reg        <= EV_STARTED;
                    copy_cnt_reg  <= '0;
                    copy_pos_reg  <= copy_base;
                end
                else
                begin
                    if (miss_new)
                    begin
                        wk_uncap_reg  <= 1'b1;
                        wk_missed_reg <= wk_missed_reg + 16'd1;
                        ev_reg        <= EV_MISSED;
                    end
                    if (uncap_after)
                    begin
                        wk_mpeak_reg <= mpeak_new;
                    end
                end
            end
            ST_COPY:
            begin
                if (ring_re)
                begin
                    copy_cnt_reg <= copy_cnt_reg + 1'b1;
                    copy_wr_reg  <= copy_cnt_reg;
                    copy_pos_reg <= (32'(copy_pos_reg) == PREROLL_DEPTH - 1)
                                  ? '0 : copy_pos_reg + 1'b1;
                end
            end
            ST_MISS_JUDGE:
            begin
                if (press_reg >= nb_reg)
                begin
                    wk_fill_reg <= '0;
                    wk_head_reg <= '0;
                end
                else
                begin
                    wk_uncap_reg <= 1'b0;
                    wk_rest_reg  <= v_reg;
                    wk_rfix_reg  <= {v_reg, 10'd0};
                end
            end
            ST_FILTER:
            begin
                if (filter_on)
                begin
                    wk_rfix_reg <= rest_sum[25:0];
                    wk_rest_reg <= rest_sum[25:10];
                end
                wk_head_reg <= (32'(wk_head_reg) == PREROLL_DEPTH - 1)
                             ? '0 : wk_head_reg + 1'b1;
                if (32'(wk_fill_reg) < PREROLL_DEPTH)
                begin
                    wk_fill_reg <= wk_fill_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                rd_reg <= store_rdata;
            end
            default:
            begin
                rd_reg <= rd_reg;
            end
        endcase
    end

    // Write back the key, clear or park keys on a sweep toggle, release done keys
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                mode_reg[i]   <= MODE_IDLE;
                rfix_reg[i]   <= '0;
                rest_reg[i]   <= '0;
                peak_reg[i]   <= '0;
                mpeak_reg[i]  <= '0;
                trunc_reg[i]  <= 1'b0;
                uncap_reg[i]  <= 1'b0;
                quiet_reg[i]  <= '0;
                head_reg[i]   <= '0;
                fill_reg[i]   <= '0;
                caplen_reg[i] <= '0;
                prelen_reg[i] <= '0;
                swings_reg[i] <= '0;
                missed_reg[i] <= '0;
            end
        end
        else if ((state_reg == ST_DECODE) && (op_reg == OP_SWEEP) && sweep_toggle)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                if (en_reg)
                begin
                    mode_reg[i]   <= MODE_IDLE;
                    rfix_reg[i]   <= '0;
                    rest_reg[i]   <= '0;
                    peak_reg[i]   <= '0;
                    mpeak_reg[i]  <= '0;
                    trunc_reg[i]  <= 1'b0;
                    uncap_reg[i]  <= 1'b0;
                    quiet_reg[i]  <= '0;
                    head_reg[i]   <= '0;
                    fill_reg[i]   <= '0;
                    caplen_reg[i] <= '0;
                    prelen_reg[i] <= '0;
                    swings_reg[i] <= '0;
                    missed_reg[i] <= '0;
                end
                else if (mode_reg[i] == MODE_ACTIVE)
                begin
                    mode_reg[i] <= MODE_IDLE;
                end
            end
        end
        else if ((state_reg == ST_DECODE) && (op_reg == OP_RELEASE) && key_ok)
        begin
            if (mode_reg[key_sel] == MODE_DONE)
            begin
                mode_reg[key_sel] <= MODE_IDLE;
            end
        end
        else if (state_reg == ST_WRITEBACK)
        begin
            mode_reg[key_sel]   <= wk_mode_reg;
            rfix_reg[key_sel]   <= wk_rfix_reg;
            rest_reg[key_sel]   <= wk_rest_reg;
            peak_reg[key_sel]   <= wk_peak_reg;
            mpeak_reg[key_sel]  <= wk_mpeak_reg;
            trunc_reg[key_sel]  <= wk_trunc_reg;
            uncap_reg[key_sel]  <= wk_uncap_reg;
            quiet_reg[key_sel]  <= wk_quiet_reg;
            head_reg[key_sel]   <= wk_head_reg;
            fill_reg[key_sel]   <= wk_fill_reg;
            caplen_reg[key_sel] <= wk_caplen_reg;
            prelen_reg[key_sel] <= wk_prelen_reg;
            swings_reg[key_sel] <= wk_swings_reg;
            missed_reg[key_sel] <= wk_missed_reg;
        end
    end

    // Write back swing times
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITEBACK)
        begin
            tstart_reg[key_sel] <= wk_tstart_reg;
            tend_reg[key_sel]   <= wk_tend_reg;
        end
    end

    // Capture the response beat
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            o_ev_reg <= ev_reg;
            o_rd_reg <= rd_reg;
            if (key_ok)
            begin
                o_mode_reg   <= mode_reg[key_sel];
                o_amp_reg    <= peak_reg[key_sel];
                o_caplen_reg <= 10'(caplen_reg[key_sel]);
                o_prelen_reg <= 5'(prelen_reg[key_sel]);
                o_trunc_reg  <= trunc_reg[key_sel];
                o_swings_reg <= swings_reg[key_sel];
                o_missed_reg <= missed_reg[key_sel];
                o_tstart_reg <= tstart_reg[key_sel];
                o_tend_reg   <= tend_reg[key_sel];
                o_rest_reg   <= rest_reg[key_sel];
            end
            else
            begin
                o_mode_reg   <= MODE_IDLE;
                o_amp_reg    <= '0;
                o_caplen_reg <= '0;
                o_prelen_reg <= '0;
                o_trunc_reg  <= 1'b0;
                o_swings_reg <= '0;
                o_missed_reg <= '0;
                o_tstart_reg <= '0;
                o_tend_reg   <= '0;
                o_rest_reg   <= '0;
            end
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign event_res      = o_ev_reg;
    assign key_mode       = o_mode_reg;
    assign amplitude      = o_amp_reg;
    assign capture_length = o_caplen_reg;
    assign preroll_length = o_prelen_reg;
    assign truncated      = o_trunc_reg;
    assign read_sample    = o_rd_reg;
    assign swing_count    = o_swings_reg;
    assign missed_count   = o_missed_reg;
    assign start_time_us  = o_tstart_reg;
    assign end_time_us    = o_tend_reg;
    assign rest_level     = o_rest_reg;

    ksc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DIV_WIDTH'(end_ms_reg) * MS_TO_US),
        .divisor  (period_new),
        .quotient (div_quo),
        .status   (div_st)
    );

    ksc_ram #(
        .WIDTH (16),
        .DEPTH (RD)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (v_reg),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    ksc_ram #(
        .WIDTH (16),
        .DEPTH (SD)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

`include "key_swing_capture_macros.svh"

    `KSC_ASSERT_NXT(a_accept_decode, req_valid && req_ready, state_reg == ST_DECODE, "accepted beat not decoded")
    `KSC_ASSERT_IMP(a_div_done_in_wait, div_st.done, state_reg == ST_DIV, "divider finished outside its wait step")
    `KSC_ASSERT_IMP(a_copy_in_range, copy_pend_reg, copy_wr_reg < wk_prelen_reg, "pre-roll copy past its count")
    `KSC_ASSERT_HOLD(a_quiet_floor, qneed_reg >= QUIET_FLOOR, "quiet count below its floor")

endmodule
